[rtl/core/ptst_pkg.sv]
// Shared types and constants for the pan/tilt PD servo tracker.
`default_nettype none

package ptst_pkg;

    // Fixed field widths
    localparam int GAIN_W   = 12;
    localparam int CENTER_W = 9;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAN_P_GAIN  = 3'd0,
        REG_PAN_D_GAIN  = 3'd1,
        REG_TILT_P_GAIN = 3'd2,
        REG_TILT_D_GAIN = 3'd3,
        REG_X_CENTER    = 3'd4,
        REG_Y_CENTER    = 3'd5,
        REG_POS_MIN     = 3'd6,
        REG_POS_MAX     = 3'd7
    } cfg_reg_t;

    // Configuration reset values
    localparam logic signed [GAIN_W-1:0] PAN_P_RST  = 12'sd350;
    localparam logic signed [GAIN_W-1:0] PAN_D_RST  = 12'sd600;
    localparam logic signed [GAIN_W-1:0] TILT_P_RST = 12'sd500;
    localparam logic signed [GAIN_W-1:0] TILT_D_RST = 12'sd700;
    localparam logic [CENTER_W-1:0]      X_CENTER_RST = 9'd158;
    localparam logic [CENTER_W-1:0]      Y_CENTER_RST = 9'd104;
    localparam logic [POS_W-1:0]         POS_MIN_RST  = 10'd0;
    localparam logic [POS_W-1:0]         POS_MAX_RST  = 10'd1000;

    // Gain scale divisor
    localparam int GAIN_DIV = 1000;

    // Axis selects
    localparam int AX_PAN  = 0;
    localparam int AX_TILT = 1;

endpackage

`default_nettype wire

[rtl/core/pan_tilt_pd_servo_tracker.sv]
// Pan/tilt tracker: box center, per-axis incremental PD step and clamp, pipelined.
// An input passes stage registers 1 to 5 and the result register on its way to m_axis.
// Throughput: one item per cycle unless m_axis_tready stalls; each loop (last error,
// position + velocity + clamp) closes within its own stage, so no stage waits on it.
// Reset (aresetn low, synchronous): gains/centers/limits to defaults, positions to
// CENTER_POS, last-error marked invalid, all pipeline stages emptied.
`default_nettype none

module pan_tilt_pd_servo_tracker #(
    parameter int COORD_BITS = 9,
    parameter int CENTER_POS = 500
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // config write port
    input  wire logic                                    cfg_we,
    input  wire logic [ptst_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [ptst_pkg::CFG_W-1:0]              cfg_wdata,
    // input stream
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata: box_left, box_right, box_top, box_bottom (COORD_BITS each), zero pad
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: blob_found
    input  wire logic                                    s_axis_tuser,
    // result stream
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // tdata: pan_position (10), tilt_position (10), zero pad
    output logic [23:0]                                  m_axis_tdata,
    // tuser: servo_updated
    output logic                                         m_axis_tuser
);

    import ptst_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int EW   = C + 2;            // error width (signed)
    localparam int DW   = EW + 1;           // error delta width (signed)
    localparam int PW   = EW + GAIN_W;      // P product width
    localparam int SW   = DW + GAIN_W + 1;  // sum width (signed)
    localparam int MW   = SW - 1;           // sum magnitude width
    localparam int K    = MW + 10;          // reciprocal shift
    localparam int QW   = MW - 9;           // quotient width
    localparam int PSW  = QW + 2;           // position sum width (signed)
    localparam longint unsigned RECIP_L =
        ((64'd1 << K) + longint'(GAIN_DIV) - 1) / longint'(GAIN_DIV);
    localparam logic [MW:0] RECIP = RECIP_L[MW:0];

    // ---------------- configuration registers ----------------
    logic signed [GAIN_W-1:0] p_gain_reg [2];
    logic signed [GAIN_W-1:0] d_gain_reg [2];
    logic [CENTER_W-1:0]      x_center_reg, y_center_reg;
    logic [POS_W-1:0]         pos_min_reg, pos_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg[AX_PAN]  <= PAN_P_RST;
            d_gain_reg[AX_PAN]  <= PAN_D_RST;
            p_gain_reg[AX_TILT] <= TILT_P_RST;
            d_gain_reg[AX_TILT] <= TILT_D_RST;
            x_center_reg        <= X_CENTER_RST;
            y_center_reg        <= Y_CENTER_RST;
            pos_min_reg         <= POS_MIN_RST;
            pos_max_reg         <= POS_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_PAN_P_GAIN:  p_gain_reg[AX_PAN]  <= cfg_wdata;
                REG_PAN_D_GAIN:  d_gain_reg[AX_PAN]  <= cfg_wdata;
                REG_TILT_P_GAIN: p_gain_reg[AX_TILT] <= cfg_wdata;
                REG_TILT_D_GAIN: d_gain_reg[AX_TILT] <= cfg_wdata;
                REG_X_CENTER:    x_center_reg <= cfg_wdata[CENTER_W-1:0];
                REG_Y_CENTER:    y_center_reg <= cfg_wdata[CENTER_W-1:0];
                REG_POS_MIN:     pos_min_reg  <= cfg_wdata[POS_W-1:0];
                REG_POS_MAX:     pos_max_reg  <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

    assign rdy_o = !vo_reg || m_axis_tready;
    assign rdy5  = !v5_reg || rdy_o;
    assign rdy4  = !v4_reg || rdy5;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1)  v1_reg <= s_axis_tvalid;
            if (rdy2)  v2_reg <= v1_reg;
            if (rdy3)  v3_reg <= v2_reg;
            if (rdy4)  v4_reg <= v3_reg;
            if (rdy5)  v5_reg <= v4_reg;
            if (rdy_o) vo_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic         found1_reg;
    logic [C-1:0] left1_reg, right1_reg, top1_reg, bottom1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_axis_tvalid) begin
            found1_reg  <= s_axis_tuser;
            left1_reg   <= s_axis_tdata[0*C +: C];
            right1_reg  <= s_axis_tdata[1*C +: C];
            top1_reg    <= s_axis_tdata[2*C +: C];
            bottom1_reg <= s_axis_tdata[3*C +: C];
        end
    end

    // ---------------- stage 1 -> 2: center, errors, delta ----------------
    logic signed [C:0]    dx, dy, hx, hy, x_mid, y_mid;
    logic signed [EW-1:0] err [2];
    logic signed [EW-1:0] last_err_reg [2];
    logic                 last_valid_reg;

    always_comb begin
        // half difference truncated toward zero
        dx    = $signed({1'b0, right1_reg}) - $signed({1'b0, left1_reg});
        dy    = $signed({1'b0, bottom1_reg}) - $signed({1'b0, top1_reg});
        hx    = (dx + $signed({{C{1'b0}}, dx[C]})) >>> 1;
        hy    = (dy + $signed({{C{1'b0}}, dy[C]})) >>> 1;
        x_mid = $signed({1'b0, left1_reg}) + hx;
        y_mid = $signed({1'b0, top1_reg}) + hy;
        err[AX_PAN]  = $signed({{(EW-CENTER_W){1'b0}}, x_center_reg})
                     - $signed({x_mid[C], x_mid});
        err[AX_TILT] = $signed({y_mid[C], y_mid})
                     - $signed({{(EW-CENTER_W){1'b0}}, y_center_reg});
    end

    logic                 upd2_reg;
    logic signed [EW-1:0] err2_reg [2];
    logic signed [DW-1:0] dlt2_reg [2];
    logic                 load2;

    assign load2 = rdy2 && v1_reg;

    // last-error state follows each blob item in order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_valid_reg <= 1'b0;
        end else if (load2 && found1_reg) begin
            last_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg[AX_PAN]  <= '0;
            last_err_reg[AX_TILT] <= '0;
        end else if (load2 && found1_reg) begin
            last_err_reg[AX_PAN]  <= err[AX_PAN];
            last_err_reg[AX_TILT] <= err[AX_TILT];
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            upd2_reg <= found1_reg && last_valid_reg;
            for (int a = 0; a < 2; a++) begin
                err2_reg[a] <= err[a];
                dlt2_reg[a] <= $signed({err[a][EW-1], err[a]})
                             - $signed({last_err_reg[a][EW-1], last_err_reg[a]});
            end
        end
    end

    // ---------------- stage 2 -> 3: gain products ----------------
    logic                 upd3_reg;
    logic signed [PW-1:0] pp3_reg [2];
    logic signed [SW-2:0] dp3_reg [2];

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            upd3_reg <= upd2_reg;
            for (int a = 0; a < 2; a++) begin
                pp3_reg[a] <= err2_reg[a] * p_gain_reg[a];
                dp3_reg[a] <= dlt2_reg[a] * d_gain_reg[a];
            end
        end
    end

    // ---------------- stage 3 -> 4: sum, sign and magnitude ----------------
    logic signed [SW-1:0] sum [2];
    logic [SW-1:0]        abs_sum [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            sum[a] = $signed({{(SW-PW){pp3_reg[a][PW-1]}}, pp3_reg[a]})
                   + $signed({dp3_reg[a][SW-2], dp3_reg[a]});
            abs_sum[a] = sum[a][SW-1] ? -sum[a] : sum[a];
        end
    end

    logic          upd4_reg;
    logic          neg4_reg [2];
    logic [MW-1:0] mag4_reg [2];

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            upd4_reg <= upd3_reg;
            for (int a = 0; a < 2; a++) begin
                neg4_reg[a] <= sum[a][SW-1];
                mag4_reg[a] <= abs_sum[a][MW-1:0];
            end
        end
    end

    // ---------------- stage 4 -> 5: divide magnitude by 1000 ----------------
    logic [2*MW:0] qprod [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            qprod[a] = {{(MW+1){1'b0}}, mag4_reg[a]} * {{MW{1'b0}}, RECIP};
        end
    end

    logic          upd5_reg;
    logic          neg5_reg [2];
    logic [QW-1:0] q5_reg [2];

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            upd5_reg <= upd4_reg;
            for (int a = 0; a < 2; a++) begin
                neg5_reg[a] <= neg4_reg[a];
                q5_reg[a]   <= qprod[a][K +: QW];
            end
        end
    end

    // ---------------- stage 5 -> out: position step and clamp ----------------
    logic [POS_W-1:0]      pos_reg [2];
    logic [POS_W-1:0]      pos_next [2];
    logic signed [QW:0]    vel [2];
    logic signed [PSW-1:0] psum [2];
    logic                  pos_ld;

    assign pos_ld = rdy_o && v5_reg && upd5_reg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            vel[a]  = neg5_reg[a] ? -$signed({1'b0, q5_reg[a]}) : $signed({1'b0, q5_reg[a]});
            psum[a] = $signed({{(PSW-POS_W){1'b0}}, pos_reg[a]})
                    + $signed({vel[a][QW], vel[a]});
            // upper limit tested first
            if (psum[a] > $signed({{(PSW-POS_W){1'b0}}, pos_max_reg})) begin
                pos_next[a] = pos_max_reg;
            end else if (psum[a] < $signed({{(PSW-POS_W){1'b0}}, pos_min_reg})) begin
                pos_next[a] = pos_min_reg;
            end else begin
                pos_next[a] = psum[a][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[AX_PAN]  <= POS_W'(CENTER_POS);
            pos_reg[AX_TILT] <= POS_W'(CENTER_POS);
        end else if (pos_ld) begin
            pos_reg[AX_PAN]  <= pos_next[AX_PAN];
            pos_reg[AX_TILT] <= pos_next[AX_TILT];
        end
    end

    // result register
    logic [POS_W-1:0] pan_out_reg, tilt_out_reg;
    logic             upd_out_reg;

    always_ff @(posedge aclk) begin
        if (rdy_o && v5_reg) begin
            upd_out_reg  <= upd5_reg;
            pan_out_reg  <= upd5_reg ? pos_next[AX_PAN]  : pos_reg[AX_PAN];
            tilt_out_reg <= upd5_reg ? pos_next[AX_TILT] : pos_reg[AX_TILT];
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {4'b0, tilt_out_reg, pan_out_reg};
    assign m_axis_tuser  = upd_out_reg;

    // ---------------- assertions ----------------
    // positions only move on an update transfer out of the last stage
    a_pos_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (pos_reg[AX_PAN] != $past(pos_reg[AX_PAN])
                            || pos_reg[AX_TILT] != $past(pos_reg[AX_TILT])))
        |-> $past(pos_ld))
        else $error("servo position changed without an update");

    // an updated result needs a recorded previous error
    a_upd_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> last_valid_reg)
        else $error("servo update before any error was recorded");

    // an empty result register means the pipeline can take an input
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vo_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
